FILE: design/sequential_list_store_defines.svh
// Assertion macros for the sequential list store.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef SEQUENTIAL_LIST_STORE_DEFINES_SVH
`define SEQUENTIAL_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define SLS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cond never holds outside reset.
`define SLS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SLS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: design/slst_pkg.sv
// Shared types and codes for the sequential list store.
// Used by slst_cell and sequential_list_store; depends on nothing.
package slst_pkg;

  // Request operations
  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_GET    = 3'd2,
    MODE_LOCATE = 3'd3,
    MODE_PRIOR  = 3'd4,
    MODE_NEXT   = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  // Per-cycle controls broadcast to every cell
  typedef struct packed {
    logic cap;  // latch the compare result against the incoming word
    logic ins;  // open a slot at the insert position
    logic del;  // close the slot at the delete position
  } cell_ctrl_t;

endpackage

FILE: design/sequential_list_store.sv
// Top level of the sequential list store: request sequencer, cell row, result pick.
// Depends on slst_pkg, slst_cell and sequential_list_store_defines.svh.
//
// Usage:
//   Requests enter on mode_i / position_i / value_i and are taken at a clock
//   edge where start is high and busy is low. Each request yields exactly one
//   result on status_o / value_out_o / position_out_o / count_o, shown for one
//   cycle with done_o high; the receiver cannot stall it and must take it then.
//   At the accepting edge the request is held and the sequencer enters its
//   execute state, at whose end the result is registered with done_o.
//   A new request is not taken while one executes. At the accepting edge every cell
//   compares its entry with the request word; in the next cycle the first-match
//   pick, the neighbor read and the shift of the cell row are done and the
//   result is registered. busy is high only for that second cycle, so a new
//   request may be taken while the previous result is on the outputs.
//   Reset (rst_ni low, asynchronous) empties the list and drops any pending
//   result; entry contents are not cleared and no clearing pass is needed,
//   since only entries below the fill count are ever read.
//   CAPACITY sets the number of cells; count_o and position_out_o keep their
//   low 7 bits.
`include "sequential_list_store_defines.svh"

module sequential_list_store import slst_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] value_out_o,
  output logic [6:0]  position_out_o,
  output logic [6:0]  count_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 7) ? CW : 7) + 1;

  state_e        state_q, state_d;
  logic [2:0]    mode_q;
  logic [6:0]    pos_q;
  logic [31:0]   val_q;
  logic [CW-1:0] fill_q, fill_d;

  logic          done_q;
  logic [1:0]    status_q, status_d;
  logic [31:0]   vout_q, vout_d;
  logic [6:0]    pout_q, pout_d;
  logic [6:0]    count_q;

  logic          accept, exec;
  cell_ctrl_t    ctrl;
  logic [31:0]   entry_w [CAPACITY];
  logic [CAPACITY-1:0] match_w, hit, vld, pos_sel, sel;
  logic          any_hit;
  logic [IW-1:0] hit_idx, p_idx;
  logic [PW-1:0] pos_w, fill_w;
  logic          ins_range, rd_ok, full;
  logic [31:0]   rd_val;

  assign accept = start && !busy;
  assign exec   = (state_q == S_EXEC);
  assign busy   = exec;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
      if (exec) fill_q <= fill_d;
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    if (exec) begin
      status_q <= status_d;
      vout_q   <= vout_d;
      pout_q   <= pout_d;
      count_q  <= 7'(fill_d);
    end
  end

  // Range checks on the held request
  assign pos_w     = PW'(pos_q);
  assign fill_w    = PW'(fill_q);
  assign p_idx     = IW'(pos_w - 1'b1);
  assign ins_range = (pos_q != '0) && (pos_w <= fill_w + 1'b1);
  assign rd_ok     = (pos_q != '0) && (pos_w <= fill_w);
  assign full      = (fill_w == PW'(CAPACITY));

  // Cell row
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [31:0] lower, upper;
    if (k == 0) begin : g_lo0
      assign lower = '0;
    end else begin : g_lo
      assign lower = entry_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_hitop
      assign upper = '0;
    end else begin : g_hi
      assign upper = entry_w[k+1];
    end
    slst_cell #(.IW(IW), .CW(CW), .IDX(k)) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .pos_idx_i   (p_idx),
      .fill_i      (fill_q),
      .cmp_value_i (value_i),
      .ins_value_i (val_q),
      .lower_i     (lower),
      .upper_i     (upper),
      .entry_o     (entry_w[k]),
      .match_o     (match_w[k])
    );
  end

  // Isolate the first match and encode its index
  assign hit     = match_w & ~(match_w - 1'b1);
  assign any_hit = |match_w;

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      vld[k]     = CW'(k) < fill_q;
      pos_sel[k] = rd_ok && (IW'(k) == p_idx);
      if (hit[k]) hit_idx = hit_idx | IW'(k);
    end
  end

  // Pick the entry to read: addressed slot, or neighbor of the first match
  always_comb begin
    case (mode_q)
      MODE_DELETE, MODE_GET: sel = pos_sel;
      MODE_PRIOR:            sel = hit >> 1;
      MODE_NEXT:             sel = (hit << 1) & vld;
      default:               sel = '0;
    endcase
  end

  always_comb begin
    rd_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_val = rd_val | (entry_w[k] & {32{sel[k]}});
    end
  end

  // Decode the operation into a result and row controls
  always_comb begin
    status_d = ST_OK;
    vout_d   = '0;
    pout_d   = '0;
    fill_d   = fill_q;
    ctrl     = '0;
    ctrl.cap = accept;
    unique case (mode_q)
      MODE_INSERT: begin
        if (!ins_range) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = exec;
          fill_d   = fill_q + 1'b1;
        end
      end
      MODE_DELETE: begin
        if (!rd_ok) begin
          status_d = ST_RANGE;
        end else begin
          ctrl.del = exec;
          vout_d   = rd_val;
          fill_d   = fill_q - 1'b1;
        end
      end
      MODE_GET: begin
        if (!rd_ok) status_d = ST_RANGE;
        else vout_d = rd_val;
      end
      MODE_LOCATE: begin
        if (!any_hit) status_d = ST_MISS;
        else pout_d = 7'(CW'(hit_idx) + 1'b1);
      end
      MODE_PRIOR, MODE_NEXT: begin
        if (!(|sel)) status_d = ST_MISS;
        else vout_d = rd_val;
      end
      MODE_CLEAR: begin
        fill_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign value_out_o    = vout_q;
  assign position_out_o = pout_q;
  assign count_o        = count_q;

  `SLS_ASSERT(a_exec_done, clk_i, rst_ni, exec |=> done_o, "result strobe missing after execute")
  `SLS_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy, "busy not raised after accept")
  `SLS_ASSERT_NEVER(a_fill_cap, clk_i, rst_ni, fill_w > PW'(CAPACITY), "fill above capacity")
  `SLS_ASSERT(a_err_zero, clk_i, rst_ni, (done_o && status_o != ST_OK) |-> (value_out_o == '0 && position_out_o == '0), "error result carries data")

endmodule

FILE: design/slst_cell.sv
// One storage cell of the list: holds a single entry and its match flag.
// Depends on slst_pkg; instantiated in a row by sequential_list_store.
module slst_cell import slst_pkg::*; #(
  parameter int IW  = 6,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  cell_ctrl_t    ctrl_i,
  input  logic [IW-1:0] pos_idx_i,
  input  logic [CW-1:0] fill_i,
  input  logic [31:0]   cmp_value_i,
  input  logic [31:0]   ins_value_i,
  input  logic [31:0]   lower_i,
  input  logic [31:0]   upper_i,
  output logic [31:0]   entry_o,
  output logic          match_o
);

  localparam logic [CW:0] KV  = IDX[CW:0];
  localparam logic [CW:0] KV1 = KV + 1'b1;

  logic [31:0] entry_q, entry_d;
  logic        match_q, match_d;
  logic [CW:0] pos_w, fill_w;

  assign pos_w  = (CW+1)'(pos_idx_i);
  assign fill_w = (CW+1)'(fill_i);

  // Take the inserted word, or shift from the neighbor below or above
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (KV == pos_w) begin
        entry_d = ins_value_i;
      end else if (KV > pos_w && KV <= fill_w) begin
        entry_d = lower_i;
      end
    end else if (ctrl_i.del) begin
      if (KV >= pos_w && KV1 < fill_w) begin
        entry_d = upper_i;
      end
    end
  end

  // Compare against the request word while the entry is in use
  always_comb begin
    match_d = match_q;
    if (ctrl_i.cap) begin
      match_d = (entry_q == cmp_value_i) && (KV < fill_w);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

FILE: tb/tb_sequential_list_store.sv
`timescale 1ns / 1ps
// Self-checking testbench for sequential_list_store: a shadow list predicts every result.
// Depends on slst_pkg and the sequential_list_store RTL; reads no files.

module tb_sequential_list_store;
  import slst_pkg::*;

  localparam int         CAPACITY    = 64;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int         MAX_REPORTS = 10;

  typedef struct {
    status_e     status;
    logic [31:0] word;
    logic [6:0]  where;
    logic [6:0]  count;
  } list_result_t;

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        start      = 1'b0;
  logic        busy;
  logic [2:0]  mode       = MODE_CLEAR;
  logic [6:0]  position   = '0;
  logic [31:0] value      = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] value_out_o;
  logic [6:0]  position_out_o;
  logic [6:0]  count_o;

  // Shadow copy of the list and the results still owed by the block
  logic [31:0]  shadow_list [CAPACITY];
  int           shadow_fill = 0;
  list_result_t pending_results [$];
  list_result_t oldest_result;
  int           fail_count  = 0;
  int           idle_pct    = 0;

  sequential_list_store #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode),
    .position_i    (position),
    .value_i       (value),
    .done_o        (done_o),
    .status_o      (status_o),
    .value_out_o   (value_out_o),
    .position_out_o(position_out_o),
    .count_o       (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("sequential_list_store verification failed");
    $finish;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Apply one request to the shadow list and return the result it must produce
  function automatic list_result_t apply_request(logic [2:0] op, logic [6:0] pos,
                                                 logic [31:0] word);
    list_result_t r;
    int hit;
    int k;
    int p;
    r.status = ST_OK;
    r.word   = '0;
    r.where  = '0;
    p        = pos;
    // Find the first entry equal to the word
    hit = shadow_fill;
    for (k = shadow_fill - 1; k >= 0; k--) if (shadow_list[k] == word) hit = k;
    case (op)
      MODE_INSERT: begin
        if (p < 1 || p > shadow_fill + 1) r.status = ST_RANGE;
        else if (shadow_fill >= CAPACITY) r.status = ST_FULL;
        else begin
          for (k = shadow_fill; k > p - 1; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = word;
          shadow_fill++;
        end
      end
      MODE_DELETE: begin
        if (p < 1 || p > shadow_fill) r.status = ST_RANGE;
        else begin
          r.word = shadow_list[p-1];
          for (k = p - 1; k + 1 < shadow_fill; k++) shadow_list[k] = shadow_list[k+1];
          shadow_fill--;
        end
      end
      MODE_GET: begin
        if (p < 1 || p > shadow_fill) r.status = ST_RANGE;
        else r.word = shadow_list[p-1];
      end
      MODE_LOCATE: begin
        if (hit >= shadow_fill) r.status = ST_MISS;
        else r.where = 7'(hit + 1);
      end
      MODE_PRIOR: begin
        if (hit >= shadow_fill || hit == 0) r.status = ST_MISS;
        else r.word = shadow_list[hit-1];
      end
      MODE_NEXT: begin
        if (hit + 1 >= shadow_fill) r.status = ST_MISS;
        else r.word = shadow_list[hit+1];
      end
      MODE_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    r.count = 7'(shadow_fill);
    return r;
  endfunction

  // Issue one transaction, predict it on acceptance, then idle at random
  task automatic send_request(logic [2:0] op, logic [6:0] pos, logic [31:0] word);
    int gap;
    start    <= 1'b1;
    mode     <= op;
    position <= pos;
    value    <= word;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(apply_request(op, pos, word));
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing expected: status %0d value %h",
                               status_o, value_out_o));
      end else begin
        oldest_result = pending_results.pop_front();
        if (status_o !== oldest_result.status || value_out_o !== oldest_result.word ||
            position_out_o !== oldest_result.where || count_o !== oldest_result.count)
          note_failure($sformatf(
            "mismatch exp/act: status %0d/%0d value %h/%h position %0d/%0d count %0d/%0d",
            oldest_result.status, status_o, oldest_result.word, value_out_o,
            oldest_result.where, position_out_o, oldest_result.count, count_o));
      end
    end
  end

  // Searches and reads on an empty list, plus bad insert positions
  task automatic test_empty_list();
    send_request(MODE_GET, 7'd1, 32'h0);
    send_request(MODE_DELETE, 7'd1, 32'h0);
    send_request(MODE_LOCATE, 7'd0, 32'h0);
    send_request(MODE_PRIOR, 7'd0, 32'h0);
    send_request(MODE_NEXT, 7'd0, 32'h0);
    send_request(MODE_INSERT, 7'd0, 32'h1234_5678);
    send_request(MODE_INSERT, 7'd2, 32'h1234_5678);
  endtask

  // Every operation on a short list, with value extremes and first-match duplicates
  task automatic test_basic_ops();
    send_request(MODE_INSERT, 7'd1, 32'h7FFF_FFFF);
    send_request(MODE_INSERT, 7'd2, 32'h8000_0000);
    send_request(MODE_INSERT, 7'd1, 32'h0000_0005);
    send_request(MODE_INSERT, 7'd127, 32'hFFFF_FFFF);
    send_request(MODE_GET, 7'd1, 32'h0);
    send_request(MODE_GET, 7'd3, 32'h0);
    send_request(MODE_GET, 7'd4, 32'h0);
    send_request(MODE_LOCATE, 7'd0, 32'h8000_0000);
    send_request(MODE_LOCATE, 7'd0, 32'hFFFF_FFFF);
    send_request(MODE_PRIOR, 7'd0, 32'h0000_0005);
    send_request(MODE_NEXT, 7'd0, 32'h8000_0000);
    send_request(MODE_PRIOR, 7'd0, 32'h8000_0000);
    send_request(MODE_NEXT, 7'd0, 32'h0000_0005);
    send_request(MODE_INSERT, 7'd4, 32'h0000_0005);
    send_request(MODE_LOCATE, 7'd0, 32'h0000_0005);
    send_request(MODE_UNUSED, 7'd127, 32'hFFFF_FFFF);
    send_request(MODE_DELETE, 7'd2, 32'h0);
    send_request(MODE_DELETE, 7'd0, 32'h0);
    send_request(MODE_CLEAR, 7'd0, 32'h0);
    send_request(MODE_GET, 7'd1, 32'h0);
  endtask

  // Fill to capacity, then hit the full and range checks at the top end
  task automatic test_full_list();
    send_request(MODE_CLEAR, 7'd0, 32'h0);
    while (shadow_fill < CAPACITY)
      send_request(MODE_INSERT, 7'($urandom_range(1, shadow_fill + 1)), $urandom);
    send_request(MODE_INSERT, 7'd1, $urandom);
    send_request(MODE_INSERT, 7'(CAPACITY + 1), $urandom);
    send_request(MODE_INSERT, 7'(CAPACITY + 2), $urandom);
    send_request(MODE_GET, 7'(CAPACITY), 32'h0);
    send_request(MODE_NEXT, 7'd0, shadow_list[CAPACITY-2]);
    send_request(MODE_DELETE, 7'(CAPACITY), 32'h0);
    send_request(MODE_INSERT, 7'(CAPACITY), $urandom);
  endtask

  // Pick a search word: mostly a stored entry, ends of the list favored
  function automatic logic [31:0] pick_search_word();
    if (shadow_fill == 0 || $urandom_range(9) < 3) return $urandom;
    case ($urandom_range(3))
      0:       return shadow_list[0];
      1:       return shadow_list[shadow_fill-1];
      default: return shadow_list[$urandom_range(shadow_fill - 1)];
    endcase
  endfunction

  // Random traffic; grow_pct sets how often an insert is issued
  task automatic test_random_traffic(int n, int grow_pct);
    int          roll;
    logic [2:0]  op;
    logic [6:0]  pos;
    logic [31:0] word;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < grow_pct) op = MODE_INSERT;
      else if (roll < 97) op = 3'($urandom_range(MODE_DELETE, MODE_NEXT));
      else if (roll < 99) op = MODE_CLEAR;
      else op = MODE_UNUSED;
      // Mostly legal positions, with ends favored; some noise across the field
      if ($urandom_range(9) == 0) pos = 7'($urandom_range(127));
      else if (op == MODE_INSERT) begin
        case ($urandom_range(3))
          0:       pos = 7'd1;
          1:       pos = 7'(shadow_fill + 1);
          default: pos = 7'($urandom_range(1, shadow_fill + 1));
        endcase
      end else if (shadow_fill > 0 && $urandom_range(3) == 0) pos = 7'(shadow_fill);
      else pos = 7'($urandom_range(1, (shadow_fill > 0) ? shadow_fill : 1));
      // Small values on insert give duplicates for the first-match searches
      if (op == MODE_INSERT) word = ($urandom_range(1) == 0) ? 32'($urandom_range(7)) : $urandom;
      else if (op inside {MODE_LOCATE, MODE_PRIOR, MODE_NEXT}) word = pick_search_word();
      else word = $urandom;
      send_request(op, pos, word);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 0;
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_traffic(385, 40);
    idle_pct = 66;
    test_random_traffic(385, 60);
    idle_pct = 30;
    test_random_traffic(385, 80);
    start <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sequential_list_store verification clean");
    end else begin
      $display("sequential_list_store verification failed");
    end
    $finish;
  end

endmodule
